[src/rfn_pkg.sv]
// ----------------------------------------------------------------------------
// rfn_pkg
// Shared types, constants and microcode codes for the fraction normalizer.
// ----------------------------------------------------------------------------
package rfn_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int DIV_CNT_W  = $clog2(DATA_WIDTH);
    localparam int STEP_W     = 3;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] numer_in;
        logic signed [DATA_WIDTH-1:0] denom_in;
    } rfn_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] numer_out;
        logic        [DATA_WIDTH-2:0] denom_out;
    } rfn_out_t;

    typedef logic [2:0] op_t;
    localparam op_t OP_NOP     = 3'd0;
    localparam op_t OP_GCD_DIV = 3'd1;
    localparam op_t OP_SUM     = 3'd2;
    localparam op_t OP_DIV_N   = 3'd3;
    localparam op_t OP_DIV_D   = 3'd4;
    localparam op_t OP_DONE    = 3'd5;

    typedef logic [1:0] cond_t;
    localparam cond_t COND_NONE    = 2'd0;
    localparam cond_t COND_ALWAYS  = 2'd1;
    localparam cond_t COND_AB_ZERO = 2'd2;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic ab_zero;
        logic div_done;
    } seq_stat_t;

    typedef struct packed {
        op_t  op;
        logic exec;
        logic div_start;
        logic div_wb;
    } seq_ctrl_t;

endpackage

[src/rational_fraction_normalizer_core.sv]
// ----------------------------------------------------------------------------
// rational_fraction_normalizer_core
// Reduces a signed fraction to lowest terms; sign on the numerator.
//
//  channel   ports                     beat taken when
//  operands  start, busy, operands     start && !busy
//  result    done, result              done (one cycle, no backpressure)
//
//  One item at a time. Every divide runs on the single shared restoring
//  divider: first the Euclid remainder steps, then the numerator and
//  denominator quotient steps.
//  busy falls on the cycle done is shown, so the next beat may enter then.
//  Reset clears control only; no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module rational_fraction_normalizer_core
    import rfn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  rfn_in_t  operands,
    output logic     done,
    output rfn_out_t result
);

    logic [DATA_WIDTH-1:0] n_raw, d_raw, n_mag, d_mag;
    logic                  accept;
    logic                  div_done;
    seq_stat_t             stat;
    seq_ctrl_t             ctrl;

    logic [DATA_WIDTH-1:0] a_reg, b_reg, g_reg, nm_reg, dm_reg, rn_reg, rd_reg;
    logic                  neg_reg, sel_reg, done_reg;
    rfn_out_t              result_reg;

    logic [DATA_WIDTH-1:0] div_n, div_d, div_q, div_r;
    logic [DATA_WIDTH-1:0] rn_sat, rd_sat;
    logic                  a_gt_b;

    assign n_raw  = operands.numer_in;
    assign d_raw  = operands.denom_in;
    assign n_mag  = n_raw[DATA_WIDTH-1] ? (~n_raw + DATA_WIDTH'(1)) : n_raw;
    assign d_mag  = d_raw[DATA_WIDTH-1] ? (~d_raw + DATA_WIDTH'(1)) : d_raw;
    assign accept = start && !busy;
    assign a_gt_b = a_reg > b_reg;

    assign stat.ab_zero  = (a_reg == '0) || (b_reg == '0);
    assign stat.div_done = div_done;

    rfn_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (accept),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    always_comb
    begin
        case (ctrl.op)
            OP_GCD_DIV:
            begin
                div_n = a_gt_b ? a_reg : b_reg;
                div_d = a_gt_b ? b_reg : a_reg;
            end
            OP_DIV_N:
            begin
                div_n = nm_reg;
                div_d = g_reg;
            end
            default:
            begin
                div_n = dm_reg;
                div_d = g_reg;
            end
        endcase
    end

    rfn_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // clamp a reduced magnitude of 2^(W-1)
    assign rn_sat = rn_reg[DATA_WIDTH-1] ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : rn_reg;
    assign rd_sat = rd_reg[DATA_WIDTH-1] ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nm_reg  <= n_mag;
            dm_reg  <= (n_mag == '0) ? DATA_WIDTH'(1) : d_mag;
            a_reg   <= n_mag;
            b_reg   <= (n_mag == '0) ? DATA_WIDTH'(1) : d_mag;
            neg_reg <= n_raw[DATA_WIDTH-1] ^ d_raw[DATA_WIDTH-1];
        end
        if (ctrl.div_start && (ctrl.op == OP_GCD_DIV))
            sel_reg <= a_gt_b;
        if (ctrl.div_wb)
        begin
            case (ctrl.op)
                OP_GCD_DIV:
                begin
                    if (sel_reg)
                        a_reg <= div_r;
                    else
                        b_reg <= div_r;
                end
                OP_DIV_N: rn_reg <= div_q;
                default:  rd_reg <= div_q;
            endcase
        end
        if (ctrl.exec && (ctrl.op == OP_SUM))
            g_reg <= a_reg + b_reg;
        if (ctrl.exec && (ctrl.op == OP_DONE))
        begin
            result_reg.numer_out <= (neg_reg && (rn_sat != '0)) ?
                                    (~rn_sat + DATA_WIDTH'(1)) : rn_sat;
            result_reg.denom_out <= rd_sat[DATA_WIDTH-2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl.exec && (ctrl.op == OP_DONE);
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer still active");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted beat did not start the sequencer");

    a_zero_numer: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.numer_out == '0)) |-> (result.denom_out == 1))
        else $error("zero numerator without unit denominator");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_start |-> busy && !stat.div_done)
        else $error("divider started outside a divide step");

endmodule

[src/rfn_divider.sv]
// ----------------------------------------------------------------------------
// rfn_divider
// Unsigned restoring divider, one quotient bit per cycle, shared by all
// remainder and quotient steps of the program.
// ----------------------------------------------------------------------------
module rfn_divider
    import rfn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] den_reg, den_next;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;

    assign shifted = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = !diff[DATA_WIDTH];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DATA_WIDTH - 1);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            quo_next = {quo_reg[DATA_WIDTH-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[src/rfn_sequencer.sv]
// ----------------------------------------------------------------------------
// rfn_sequencer
// Step counter and microcode ROM; holds divide steps until the divider
// finishes and applies conditional jumps.
// ----------------------------------------------------------------------------
module rfn_sequencer
    import rfn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  seq_stat_t stat,
    output seq_ctrl_t ctrl,
    output logic      busy
);

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
        ucode_t w;
        unique case (addr)
            3'd0:    w = '{op: OP_NOP,     cond: COND_AB_ZERO, target: 3'd2};
            3'd1:    w = '{op: OP_GCD_DIV, cond: COND_ALWAYS,  target: 3'd0};
            3'd2:    w = '{op: OP_SUM,     cond: COND_NONE,    target: 3'd0};
            3'd3:    w = '{op: OP_DIV_N,   cond: COND_NONE,    target: 3'd0};
            3'd4:    w = '{op: OP_DIV_D,   cond: COND_NONE,    target: 3'd0};
            default: w = '{op: OP_DONE,    cond: COND_NONE,    target: 3'd0};
        endcase
        return w;
    endfunction

    logic              active_reg, active_next;
    logic              wait_reg, wait_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            word;
    logic              is_div;
    logic              advance;
    logic              taken;

    assign word   = ucode_rom(step_reg);
    assign is_div = (word.op == OP_GCD_DIV) || (word.op == OP_DIV_N) ||
                    (word.op == OP_DIV_D);

    always_comb
    begin
        unique case (word.cond)
            COND_ALWAYS:  taken = 1'b1;
            COND_AB_ZERO: taken = stat.ab_zero;
            default:      taken = 1'b0;
        endcase
    end

    always_comb
    begin
        active_next    = active_reg;
        wait_next      = wait_reg;
        step_next      = step_reg;
        advance        = 1'b0;
        ctrl.op        = word.op;
        ctrl.exec      = 1'b0;
        ctrl.div_start = 1'b0;
        ctrl.div_wb    = 1'b0;
        if (!active_reg)
        begin
            if (go)
            begin
                active_next = 1'b1;
                wait_next   = 1'b0;
                step_next   = '0;
            end
        end
        else if (is_div)
        begin
            if (!wait_reg)
            begin
                ctrl.div_start = 1'b1;
                wait_next      = 1'b1;
            end
            else if (stat.div_done)
            begin
                ctrl.div_wb = 1'b1;
                wait_next   = 1'b0;
                advance     = 1'b1;
            end
        end
        else
        begin
            ctrl.exec = 1'b1;
            advance   = 1'b1;
        end
        if (advance)
        begin
            if (word.op == OP_DONE)
                active_next = 1'b0;
            else if (taken)
                step_next = word.target;
            else
                step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            wait_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            wait_reg   <= wait_next;
            step_reg   <= step_next;
        end
    end

    assign busy = active_reg;

endmodule
